/* design/usbpd_pkg.sv */
package usbpd_pkg;

  // Capture geometry
  localparam int unsigned MAX_REG_BYTES = 64;
  localparam int unsigned PDO_SLOTS     = 7;
  localparam int unsigned POS_W         = $clog2(MAX_REG_BYTES + 1);
  localparam logic [POS_W-1:0] PDO_END_BYTE = POS_W'(4 * PDO_SLOTS);
  localparam logic [POS_W-1:0] MAX_POS      = POS_W'(MAX_REG_BYTES);

  // Length register
  localparam int unsigned LEN_W = 7;
  localparam logic [LEN_W-1:0] EXPECTED_LENGTH_RESET = 7'd29;

  // PDO type codes
  localparam logic [1:0] PDO_FIXED    = 2'd0;
  localparam logic [1:0] PDO_BATTERY  = 2'd1;
  localparam logic [1:0] PDO_VARIABLE = 2'd2;
  localparam logic [1:0] PDO_PPS      = 2'd3;

  // Result kinds
  localparam logic KIND_PDO     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Band for the first fixed PDO, millivolts
  localparam logic [15:0] VSAFE_MIN_MV = 16'd4750;
  localparam logic [15:0] VSAFE_MAX_MV = 16'd5250;

  // Output queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Decoded PDO
  typedef struct packed {
    logic [1:0]  pdo_type;
    logic [15:0] voltage_high_mv;
    logic [15:0] voltage_low_mv;
    logic [17:0] current_or_power;
    logic [6:0]  fixed_flags;
    logic        pdo_ok;
  } pdo_rec_t;

  // One result item
  typedef struct packed {
    logic        result_kind;
    logic        last_result;
    logic [2:0]  pdo_total;
    logic        register_valid;
    logic        caps_present;
    logic        pdo_ok;
    logic [6:0]  fixed_flags;
    logic [17:0] current_or_power;
    logic [15:0] voltage_low_mv;
    logic [15:0] voltage_high_mv;
    logic [1:0]  pdo_type;
    logic [2:0]  pdo_index;
  } result_t;

endpackage

/* design/usb_pd_sink_caps_checker.sv */
// USB PD sink capabilities checker.
// Input stream: one register byte per request, byte 0 first; tlast marks the
// final byte and tuser carries the header status, sampled on that byte.
// Byte 0 gives the PDO count; the next 28 bytes build up to seven 32-bit PDOs
// little-endian. Each completed PDO below the count yields a PDO record, and
// the final byte yields a verdict record (after the PDO record, if any).
// Output stream: tuser is the record kind, tlast flags the final record
// caused by one input byte.
// Records are written into the output queue and offered from its head.
// Throughput: one byte per cycle while the sink keeps up; a byte that yields
// two records needs two output transfers, as there is a single output port.
// A four-entry output queue decouples the sides; tready drops once fewer
// than two free entries would remain, so a stalled sink holds the input off.
// Reset empties the queue, clears the capture state and sets the expected
// length to 29. cfg_we writes the expected length; write it only when idle.
module usb_pd_sink_caps_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // header_ok
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] pdo_index, [4:3] pdo_type, [20:5] voltage_high_mv,
  // [36:21] voltage_low_mv, [54:37] current_or_power, [61:55] fixed_flags,
  // [62] pdo_ok, [63] caps_present, [64] register_valid, [67:65] pdo_total,
  // [71:68] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last_result
  output logic        m_axis_tuser    // result_kind
);

  localparam int unsigned PW = usbpd_pkg::POS_W;

  // Capture state
  logic [usbpd_pkg::LEN_W-1:0] expected_length;
  logic [PW-1:0]  byte_position;
  logic [23:0]    word_assembly;
  logic [2:0]     count_held;
  logic           first_pdo_nonzero;
  logic           all_pdos_ok;

  logic [PW-1:0]  byte_position_next;
  logic [23:0]    word_assembly_next;
  logic [2:0]     count_held_next;
  logic           first_pdo_nonzero_next;
  logic           all_pdos_ok_next;

  logic           accept;
  logic [PW-1:0]  off;
  logic [1:0]     lane;
  logic [2:0]     idx;
  logic [31:0]    pdo;
  logic           emit_pdo;
  logic [PW-1:0]  done_raw;
  logic [2:0]     done;
  logic           caps;
  logic           valid;

  usbpd_pkg::pdo_rec_t rec;
  usbpd_pkg::result_t  pdo_res;
  usbpd_pkg::result_t  verdict_res;
  usbpd_pkg::result_t  din0;
  usbpd_pkg::result_t  din1;
  usbpd_pkg::result_t  head;
  logic                push0;
  logic                push1;
  logic                room2;
  logic                not_empty;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign off    = byte_position - PW'(1);
  assign lane   = off[1:0];
  assign idx    = off[4:2];
  assign pdo    = {s_axis_tdata, word_assembly};

  usbpd_pdo_decode u_decode (
    .pdo (pdo),
    .idx (idx),
    .rec (rec)
  );

  // Assemble PDOs and update capture state for this byte
  always_comb begin
    byte_position_next     = byte_position;
    word_assembly_next     = word_assembly;
    count_held_next        = count_held;
    first_pdo_nonzero_next = first_pdo_nonzero;
    all_pdos_ok_next       = all_pdos_ok;
    emit_pdo               = 1'b0;
    if (byte_position < usbpd_pkg::MAX_POS) begin
      if (byte_position == '0) begin
        count_held_next = s_axis_tdata[2:0];
      end else if (byte_position <= usbpd_pkg::PDO_END_BYTE) begin
        case (lane)
          2'd0: word_assembly_next = {16'd0, s_axis_tdata};
          2'd1: word_assembly_next = {word_assembly[23:16], s_axis_tdata, word_assembly[7:0]};
          2'd2: word_assembly_next = {s_axis_tdata, word_assembly[15:0]};
          default: begin
            word_assembly_next = '0;
            if (idx == 3'd0) begin
              first_pdo_nonzero_next = (pdo != '0);
            end
            if (idx < count_held) begin
              emit_pdo = 1'b1;
              if (!rec.pdo_ok) begin
                all_pdos_ok_next = 1'b0;
              end
            end
          end
        endcase
      end
      byte_position_next = byte_position + PW'(1);
    end
  end

  // Verdict from the updated state
  always_comb begin
    done_raw = (byte_position_next - PW'(1)) >> 2;
    if (byte_position_next == '0) begin
      done = 3'd0;
    end else if (done_raw > PW'(usbpd_pkg::PDO_SLOTS)) begin
      done = 3'(usbpd_pkg::PDO_SLOTS);
    end else begin
      done = done_raw[2:0];
    end
    caps  = (count_held_next != 3'd0) && first_pdo_nonzero_next;
    valid = s_axis_tuser &&
            (byte_position_next == PW'(expected_length)) &&
            (!caps || (all_pdos_ok_next && (count_held_next <= done)));
  end

  // Build the records
  always_comb begin
    pdo_res                  = '0;
    pdo_res.result_kind      = usbpd_pkg::KIND_PDO;
    pdo_res.last_result      = !s_axis_tlast;
    pdo_res.pdo_total        = count_held;
    pdo_res.pdo_index        = idx;
    pdo_res.pdo_type         = rec.pdo_type;
    pdo_res.voltage_high_mv  = rec.voltage_high_mv;
    pdo_res.voltage_low_mv   = rec.voltage_low_mv;
    pdo_res.current_or_power = rec.current_or_power;
    pdo_res.fixed_flags      = rec.fixed_flags;
    pdo_res.pdo_ok           = rec.pdo_ok;

    verdict_res                = '0;
    verdict_res.result_kind    = usbpd_pkg::KIND_VERDICT;
    verdict_res.last_result    = 1'b1;
    verdict_res.pdo_total      = count_held_next;
    verdict_res.caps_present   = caps;
    verdict_res.register_valid = valid;
  end

  // Queue the records in order: PDO record first, then the verdict
  assign din0  = emit_pdo ? pdo_res : verdict_res;
  assign din1  = verdict_res;
  assign push0 = accept && (emit_pdo || s_axis_tlast);
  assign push1 = accept && emit_pdo && s_axis_tlast;

  usbpd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .din0      (din0),
    .din1      (din1),
    .pop       (m_axis_tready),
    .dout      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  assign s_axis_tready = room2;
  assign m_axis_tvalid = not_empty;
  assign m_axis_tuser  = head.result_kind;
  assign m_axis_tlast  = head.last_result;
  assign m_axis_tdata  = {4'd0, head.pdo_total, head.register_valid, head.caps_present,
                          head.pdo_ok, head.fixed_flags, head.current_or_power,
                          head.voltage_low_mv, head.voltage_high_mv, head.pdo_type,
                          head.pdo_index};

  // Hold the expected length
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= usbpd_pkg::EXPECTED_LENGTH_RESET;
    end else if (cfg_we) begin
      expected_length <= cfg_data;
    end
  end

  // Advance the capture; drop it back to reset after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      word_assembly     <= '0;
      count_held        <= '0;
      first_pdo_nonzero <= 1'b0;
      all_pdos_ok       <= 1'b1;
    end else if (accept) begin
      if (s_axis_tlast) begin
        byte_position     <= '0;
        word_assembly     <= '0;
        count_held        <= '0;
        first_pdo_nonzero <= 1'b0;
        all_pdos_ok       <= 1'b1;
      end else begin
        byte_position     <= byte_position_next;
        word_assembly     <= word_assembly_next;
        count_held        <= count_held_next;
        first_pdo_nonzero <= first_pdo_nonzero_next;
        all_pdos_ok       <= all_pdos_ok_next;
      end
    end
  end

endmodule

/* design/usbpd_pdo_decode.sv */
module usbpd_pdo_decode (
  input  logic [31:0]        pdo,
  input  logic [2:0]         idx,
  output usbpd_pkg::pdo_rec_t rec
);

  logic [1:0]  ptype;
  logic [9:0]  lo10;
  logic [9:0]  mid10;
  logic [9:0]  hi10;
  logic [15:0] vh;
  logic [15:0] vl;
  logic [17:0] cp;
  logic [6:0]  flags;
  logic        ok;

  assign ptype = pdo[31:30];
  assign lo10  = pdo[9:0];
  assign mid10 = pdo[19:10];
  assign hi10  = pdo[29:20];

  // Scale the fields by type and run the per-type check
  always_comb begin
    vh    = '0;
    vl    = '0;
    cp    = '0;
    flags = '0;
    ok    = 1'b0;
    case (ptype)
      usbpd_pkg::PDO_FIXED: begin
        vh    = 16'({6'd0, mid10} * 16'd50);
        cp    = 18'({8'd0, lo10} * 18'd10);
        flags = pdo[29:23];
        ok    = (vh != '0) && (cp != '0) &&
                ((idx != 3'd0) ||
                 ((vh >= usbpd_pkg::VSAFE_MIN_MV) && (vh <= usbpd_pkg::VSAFE_MAX_MV)));
      end
      usbpd_pkg::PDO_PPS: begin
        vh = 16'({8'd0, pdo[24:17]} * 16'd100);
        vl = 16'({8'd0, pdo[15:8]} * 16'd100);
        cp = 18'({11'd0, pdo[6:0]} * 18'd50);
        ok = (vl <= vh) && (vl != '0) && (vh != '0) && (cp != '0);
      end
      default: begin
        vh = 16'({6'd0, hi10} * 16'd50);
        vl = 16'({6'd0, mid10} * 16'd50);
        if (ptype == usbpd_pkg::PDO_BATTERY) begin
          cp = 18'({8'd0, lo10} * 18'd250);
        end else begin
          cp = 18'({8'd0, lo10} * 18'd10);
        end
        ok = (vl <= vh) && (vl != '0) && (vh != '0) && (cp != '0);
      end
    endcase
  end

  assign rec.pdo_type         = ptype;
  assign rec.voltage_high_mv  = vh;
  assign rec.voltage_low_mv   = vl;
  assign rec.current_or_power = cp;
  assign rec.fixed_flags      = flags;
  assign rec.pdo_ok           = ok;

endmodule

/* design/usbpd_out_fifo.sv */
module usbpd_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push0,
  input  logic                push1,
  input  usbpd_pkg::result_t  din0,
  input  usbpd_pkg::result_t  din1,
  input  logic                pop,
  output usbpd_pkg::result_t  dout,
  output logic                not_empty,
  output logic                room2
);

  localparam int unsigned PW = usbpd_pkg::FIFO_PTR_W;

  usbpd_pkg::result_t      mem [usbpd_pkg::FIFO_DEPTH];
  logic [PW-1:0]           wr_ptr;
  logic [PW-1:0]           rd_ptr;
  logic [PW:0]             count;
  logic [PW-1:0]           wr_ptr_inc;
  logic [PW:0]             count_after_pop;
  logic [PW:0]             push_n;
  logic                    do_pop;

  assign do_pop          = pop && not_empty;
  assign not_empty       = (count != '0);
  assign count_after_pop = count - (PW + 1)'(do_pop);
  // Room for a full pair once this cycle's request has left
  assign room2           = (count_after_pop <= (PW + 1)'(usbpd_pkg::FIFO_DEPTH - 2));
  assign wr_ptr_inc      = wr_ptr + PW'(1);
  assign push_n          = (PW + 1)'(push0) + (PW + 1)'(push1);
  assign dout            = mem[rd_ptr];

  // Store up to two results a cycle, in order
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= din0;
    end
    if (push1) begin
      mem[wr_ptr_inc] <= din1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count_after_pop + push_n;
    end
  end

endmodule
